// ===== rtl/core/lads_pkg.sv =====
// Shared types and constants of the lattice affine deviation sum unit.
`timescale 1ns / 1ps
`default_nettype none
package lads_pkg;

  // Widths fixed by the transaction fields.
  localparam int unsigned Q_W    = 32;  // Q16.16 positions and shear
  localparam int unsigned SUM_W  = 64;  // Q32.32 sum
  localparam int unsigned GRID_W = 7;   // grid size register
  localparam int unsigned FRAC_W = 16;  // fractional bits of Q16.16

  // sqrt(3)/2 as an unsigned Q0.32 value.
  localparam logic [Q_W-1:0] SQRT3_HALF_Q32 = 32'hDDB3D743;
  // Half of one Q16.16 LSB after the Q0.32 product, for round half up.
  localparam int unsigned ROUND_HALF = 32768;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_OFFSET = 1'b1;

  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

  // Classification flags that the front end attaches to each queued node.
  typedef struct packed {
    logic last;    // final node of the sweep
    logic active;  // shear is non-zero, so the node contributes
  } lads_flags_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_ABS,
    BK_DIV,
    BK_REF,
    BK_DEV,
    BK_MAG,
    BK_SQX,
    BK_SQY,
    BK_ACC,
    BK_FIN
  } lads_state_e;

endpackage
`default_nettype wire

// ===== rtl/core/lads_fifo.sv =====
// Small register queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module lads_fifo #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [DataW-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lads_front.sv =====
// Front end: accepts node transactions, tracks row and column, tags each node.
`timescale 1ns / 1ps
`default_nettype none
module lads_front #(
  parameter int unsigned MAX_GRID = 64,
  localparam int unsigned CntW = $clog2(MAX_GRID),
  localparam int unsigned EntryW = 2 * lads_pkg::Q_W + 3 * CntW
                                   + $bits(lads_pkg::lads_flags_t)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [lads_pkg::Q_W-1:0]    pos_x_i,
  input  wire logic signed [lads_pkg::Q_W-1:0]    pos_y_i,
  input  wire logic        [lads_pkg::GRID_W-1:0] grid_size_i,
  input  wire logic signed [lads_pkg::Q_W-1:0]    shear_i,
  input  wire logic                               full_i,
  output logic                                    push_o,
  output logic             [EntryW-1:0]           entry_o
);

  import lads_pkg::*;

  localparam int unsigned GeffW = $clog2(MAX_GRID + 1);
  localparam int unsigned GextW = (GeffW > GRID_W) ? GeffW : GRID_W;

  logic [CntW-1:0]  row_q, row_d;
  logic [CntW-1:0]  col_q, col_d;
  logic [GextW-1:0] grid_ext, grid_eff;
  logic [CntW-1:0]  gm1;
  logic             last_col, last_row;
  lads_flags_t      flags;

  // Clamp the grid size into the supported range.
  always_comb begin
    grid_ext = GextW'(grid_size_i);
    if (grid_ext < GextW'(2)) begin
      grid_eff = GextW'(2);
    end else if (grid_ext > GextW'(MAX_GRID)) begin
      grid_eff = GextW'(MAX_GRID);
    end else begin
      grid_eff = grid_ext;
    end
  end

  assign gm1      = CntW'(grid_eff - GextW'(1));
  assign last_col = (col_q >= gm1);
  assign last_row = (row_q >= gm1);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  assign flags.last   = last_col && last_row;
  assign flags.active = (shear_i != '0);
  assign entry_o      = {pos_x_i, pos_y_i, row_q, col_q, gm1, flags};

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lads_back.sv =====
// Back end: reference position, squared deviations and the saturating sum.
`timescale 1ns / 1ps
`default_nettype none
module lads_back #(
  parameter int unsigned MAX_GRID = 64,
  localparam int unsigned CntW = $clog2(MAX_GRID),
  localparam int unsigned EntryW = 2 * lads_pkg::Q_W + 3 * CntW
                                   + $bits(lads_pkg::lads_flags_t)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            flush_i,
  input  wire logic signed [lads_pkg::Q_W-1:0] shear_i,
  input  wire logic                            empty_i,
  input  wire logic        [EntryW-1:0]        entry_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [lads_pkg::SUM_W-1:0]           deviation_sum_o,
  output logic                                 overflowed_o
);

  import lads_pkg::*;

  localparam int unsigned FacW    = CntW + 2;
  localparam int unsigned NumW    = Q_W + FacW;
  localparam int unsigned DenW    = CntW + 1;
  localparam int unsigned DivCntW = $clog2(NumW);
  localparam int unsigned RefW    = NumW + 2;
  localparam int unsigned DevW    = RefW + 1;
  localparam int unsigned YProdW  = CntW + Q_W + 1;
  localparam int unsigned YW      = YProdW - FRAC_W;
  localparam int unsigned FlagW   = $bits(lads_flags_t);

  // Queue entry fields.
  logic signed [Q_W-1:0] in_px, in_py;
  logic [CntW-1:0]       in_row, in_col, in_gm1;
  lads_flags_t           in_flags;

  assign in_px    = entry_i[EntryW-1 -: Q_W];
  assign in_py    = entry_i[EntryW-Q_W-1 -: Q_W];
  assign in_row   = entry_i[FlagW+3*CntW-1 -: CntW];
  assign in_col   = entry_i[FlagW+2*CntW-1 -: CntW];
  assign in_gm1   = entry_i[FlagW+CntW-1 -: CntW];
  assign in_flags = lads_flags_t'(entry_i[FlagW-1:0]);

  lads_state_e state_q, state_d;

  // Node under work.
  logic signed [Q_W-1:0] px_q, py_q;
  logic [CntW-1:0]       row_q, col_q, gm1_q;
  lads_flags_t           flags_q;

  // Per-row reference, kept while the row and the configuration hold.
  logic                  cache_vld_q, cache_vld_d;
  logic [CntW-1:0]       cache_row_q, cache_row_d;
  logic signed [NumW-1:0] num_q, num_d;
  logic [YW-1:0]         refy_q, refy_d;
  logic                  sgn_q, sgn_d;
  logic [NumW-1:0]       dd_q, dd_d;
  logic [DenW-1:0]       rem_q, rem_d;
  logic [DivCntW-1:0]    div_cnt_q, div_cnt_d;

  // Deviation datapath.
  logic signed [RefW-1:0] refx_q, refx_d;
  logic signed [DevW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [Q_W-1:0]         magx_q, magx_d, magy_q, magy_d;
  logic                   ovx_q, ovx_d, ovy_q, ovy_d;
  logic [SUM_W-1:0]       prod_q, prod_d;

  // Sum and result register.
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   sat_q, sat_d;
  logic                   out_valid_q, out_valid_d;
  logic [SUM_W-1:0]       out_sum_q, out_sum_d;
  logic                   out_ovf_q, out_ovf_d;

  logic                   out_free, cache_hit;
  logic signed [FacW-1:0] factor;
  logic signed [NumW-1:0] num_prod;
  logic [YProdW-1:0]      refy_full;
  logic [NumW-1:0]        num_mag;
  logic [DenW-1:0]        den;
  logic [DenW:0]          rem_sh, rem_sub;
  logic                   rem_ge;
  logic signed [RefW-1:0] term;
  logic [DevW-1:0]        magx_full, magy_full;
  logic [SUM_W:0]         acc_sum;
  logic                   acc_ov;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign cache_hit = cache_vld_q && (cache_row_q == in_row);
  assign pop_o     = (state_q == BK_IDLE) && !empty_i;

  // Shear numerator: shear * (2*row - (g-1)).
  assign factor   = $signed({1'b0, row_q, 1'b0}) - $signed({2'b00, gm1_q});
  assign num_prod = shear_i * factor;
  assign refy_full = YProdW'(row_q) * YProdW'(SQRT3_HALF_Q32) + YProdW'(ROUND_HALF);

  assign num_mag = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);

  // One restoring division step: quotient bits shift into dd_q from the right.
  assign den     = {gm1_q, 1'b0};
  assign rem_sh  = {rem_q, dd_q[NumW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den});
  assign rem_sub = rem_sh - {1'b0, den};

  assign term = sgn_q ? -$signed({2'b00, dd_q}) : $signed({2'b00, dd_q});

  assign magx_full = dx_q[DevW-1] ? DevW'(-dx_q) : DevW'(dx_q);
  assign magy_full = dy_q[DevW-1] ? DevW'(-dy_q) : DevW'(dy_q);

  assign acc_ov  = (state_q == BK_SQY) ? ovx_q : ovy_q;
  assign acc_sum = {1'b0, sum_q} + {1'b0, prod_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          if (!in_flags.active) begin
            state_d = BK_FIN;
          end else if (cache_hit) begin
            state_d = BK_REF;
          end else begin
            state_d = BK_MUL;
          end
        end
      end
      BK_MUL: state_d = BK_ABS;
      BK_ABS: state_d = BK_DIV;
      BK_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = BK_REF;
        end
      end
      BK_REF: state_d = BK_DEV;
      BK_DEV: state_d = BK_MAG;
      BK_MAG: state_d = BK_SQX;
      BK_SQX: state_d = BK_SQY;
      BK_SQY: state_d = BK_ACC;
      BK_ACC: state_d = BK_FIN;
      BK_FIN: begin
        if (!flags_q.last || out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cache_vld_d = cache_vld_q;
    cache_row_d = cache_row_q;
    num_d       = num_q;
    refy_d      = refy_q;
    sgn_d       = sgn_q;
    dd_d        = dd_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    refx_d      = refx_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    magx_d      = magx_q;
    magy_d      = magy_q;
    ovx_d       = ovx_q;
    ovy_d       = ovy_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    out_sum_d   = out_sum_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      BK_IDLE: ;
      BK_MUL: begin
        num_d  = num_prod;
        refy_d = refy_full[YProdW-1:FRAC_W];
      end
      BK_ABS: begin
        sgn_d     = num_q[NumW-1];
        dd_d      = num_mag + NumW'(gm1_q);
        rem_d     = '0;
        div_cnt_d = DivCntW'(NumW - 1);
      end
      BK_DIV: begin
        rem_d     = rem_ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
        dd_d      = {dd_q[NumW-2:0], rem_ge};
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          cache_vld_d = 1'b1;
          cache_row_d = row_q;
        end
      end
      BK_REF: begin
        refx_d = $signed({{(RefW-CntW-FRAC_W){1'b0}}, col_q, {FRAC_W{1'b0}}})
               + $signed({{(RefW-CntW-FRAC_W+1){1'b0}}, row_q, {(FRAC_W-1){1'b0}}})
               + term;
      end
      BK_DEV: begin
        dx_d = DevW'(px_q) - DevW'(refx_q);
        dy_d = DevW'(py_q) - $signed(DevW'(refy_q));
      end
      BK_MAG: begin
        magx_d = magx_full[Q_W-1:0];
        magy_d = magy_full[Q_W-1:0];
        ovx_d  = |magx_full[DevW-1:Q_W];
        ovy_d  = |magy_full[DevW-1:Q_W];
      end
      BK_SQX: begin
        prod_d = SUM_W'(magx_q) * SUM_W'(magx_q);
      end
      BK_SQY, BK_ACC: begin
        if (acc_ov || acc_sum[SUM_W]) begin
          sum_d = '1;
          sat_d = 1'b1;
        end else begin
          sum_d = acc_sum[SUM_W-1:0];
        end
        if (state_q == BK_SQY) begin
          prod_d = SUM_W'(magy_q) * SUM_W'(magy_q);
        end
      end
      BK_FIN: begin
        if (flags_q.last && out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = sum_q;
          out_ovf_d   = sat_q;
          sum_d       = '0;
          sat_d       = 1'b0;
        end
      end
      default: ;
    endcase

    if (flush_i) begin
      cache_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cache_vld_q <= 1'b0;
      div_cnt_q   <= '0;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cache_vld_q <= cache_vld_d;
      div_cnt_q   <= div_cnt_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      px_q    <= in_px;
      py_q    <= in_py;
      row_q   <= in_row;
      col_q   <= in_col;
      gm1_q   <= in_gm1;
      flags_q <= in_flags;
    end
    cache_row_q <= cache_row_d;
    num_q       <= num_d;
    refy_q      <= refy_d;
    sgn_q       <= sgn_d;
    dd_q        <= dd_d;
    rem_q       <= rem_d;
    refx_q      <= refx_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    magx_q      <= magx_d;
    magy_q      <= magy_d;
    ovx_q       <= ovx_d;
    ovy_q       <= ovy_d;
    prod_q      <= prod_d;
    out_sum_q   <= out_sum_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign deviation_sum_o = out_sum_q;
  assign overflowed_o    = out_ovf_q;

endmodule
`default_nettype wire

// ===== rtl/core/lattice_affine_deviation_sum_unit.sv =====
// Top level of the lattice affine deviation sum unit.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake               Payload
// node      in         in_valid_i / in_stall_o pos_x_i, pos_y_i (Q16.16)
// result    out        out_valid_o/out_stall_i deviation_sum_o (Q32.32), overflowed_o
// config    in         cfg_we_i                cfg_index_i, cfg_wdata_i
//
// A node with zero shear goes from idle straight to finish; any other node
// passes the reference, deviation, magnitude, square, accumulate and finish
// states, and the first node of each row first forms the shear numerator, folds
// its sign and divides the shear term at one quotient bit per cycle.
// Reset clears the counters, the sum, the queue and the per-row term cache; the
// grid size comes up as 64 and the shear as zero. The front end keeps accepting
// while the queue has room, and a held result stalls only the next last node.
module lattice_affine_deviation_sum_unit #(
  parameter int unsigned MAX_GRID    = 64,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [lads_pkg::Q_W-1:0]     pos_x_i,
  input  wire logic signed [lads_pkg::Q_W-1:0]     pos_y_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic        [lads_pkg::SUM_W-1:0]        deviation_sum_o,
  output logic                                     overflowed_o,
  input  wire logic                                cfg_we_i,
  input  wire logic        [lads_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [lads_pkg::Q_W-1:0]     cfg_wdata_i
);

  import lads_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_GRID);
  localparam int unsigned EntryW = 2 * Q_W + 3 * CntW + $bits(lads_flags_t);

  // Configuration registers. The user must make writes only while no transaction
  // is in flight (the block does not enforce it), so both halves read them directly.
  logic [GRID_W-1:0]     grid_size_q, grid_size_d;
  logic signed [Q_W-1:0] shear_q, shear_d;

  always_comb begin
    grid_size_d = grid_size_q;
    shear_d     = shear_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_SIZE:    grid_size_d = cfg_wdata_i[GRID_W-1:0];
        CFG_SHEAR_OFFSET: shear_d     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_RESET;
      shear_q     <= '0;
    end else begin
      grid_size_q <= grid_size_d;
      shear_q     <= shear_d;
    end
  end

  logic              push, pop, full, empty;
  logic [EntryW-1:0] entry_wr, entry_rd;

  // The front end counts row and column and tags the last node of a sweep.
  lads_front #(
    .MAX_GRID(MAX_GRID)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .pos_x_i,
    .pos_y_i,
    .grid_size_i(grid_size_q),
    .shear_i    (shear_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry_wr)
  );

  lads_fifo #(
    .DataW(EntryW),
    .Depth(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .wdata_i(entry_wr),
    .pop_i  (pop),
    .rdata_o(entry_rd),
    .full_o (full),
    .empty_o(empty)
  );

  // The back end holds the per-row shear term and refreshes it after any
  // configuration write, since both the shear and the grid size feed it.
  lads_back #(
    .MAX_GRID(MAX_GRID)
  ) u_back (
    .clk_i,
    .rst_ni,
    .flush_i        (cfg_we_i),
    .shear_i        (shear_q),
    .empty_i        (empty),
    .entry_i        (entry_rd),
    .pop_o          (pop),
    .out_valid_o,
    .out_stall_i,
    .deviation_sum_o,
    .overflowed_o
  );

endmodule
`default_nettype wire
